FILE: hdl/tcspq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcspq_pkg
// Types, operation and status codes, and the ordering rule shared by the
// sorted priority queue cells and the top level.
// ----------------------------------------------------------------------------
package tcspq_pkg;

  localparam logic [1:0] FUNC_INSERT  = 2'd0;
  localparam logic [1:0] FUNC_EXTRACT = 2'd1;
  localparam logic [1:0] FUNC_CLEAR   = 2'd2;
  localparam logic [1:0] FUNC_NONE    = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam int OCC_W = 5;

  typedef struct packed {
    logic [15:0] id;
    logic        prio;
    logic [15:0] arr_time;
  } entry_t;

  // Operation broadcast to every cell in the row.
  typedef struct packed {
    logic insert;
    logic extract;
  } cell_ctl_t;

  // True when entry a must be served before entry b.
  function automatic logic goes_before(input entry_t a, input entry_t b);
    logic res;
    if (a.prio != b.prio) begin
      res = a.prio;
    end else begin
      res = (a.arr_time < b.arr_time);
    end
    return res;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/tcspq_req_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcspq_req_if
// Request channel: one operation word per handshake.
// ----------------------------------------------------------------------------
interface tcspq_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic        is_priority;
  logic [15:0] arrival_time;
  logic [15:0] entry_id;

  modport source (output valid, func, is_priority, arrival_time, entry_id,
                  input ready);
  modport sink (input valid, func, is_priority, arrival_time, entry_id,
                output ready);
endinterface
`default_nettype wire

FILE: hdl/tcspq_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcspq_rsp_if
// Result channel: one result word per handshake.
// ----------------------------------------------------------------------------
interface tcspq_rsp_if;
  logic        valid;
  logic        ready;
  logic        out_valid;
  logic [15:0] out_id;
  logic        out_priority;
  logic [15:0] out_time;
  logic [4:0]  occupancy;
  logic [1:0]  status;

  modport source (output valid, out_valid, out_id, out_priority, out_time,
                  occupancy, status, input ready);
  modport sink (input valid, out_valid, out_id, out_priority, out_time,
                occupancy, status, output ready);
endinterface
`default_nettype wire

FILE: hdl/two_class_sorted_priority_queue_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// two_class_sorted_priority_queue_core
// Sorted queue of up to QUEUE_DEPTH entries built as a row of cells.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one operation per word: insert, extract head, clear all or none.
//   rsp returns exactly one result word for each request word, in order.
//   Every cell compares the broadcast entry with its own in the same cycle,
//   so each operation is settled in one step: the result word appears on
//   rsp in the cycle after the request is taken. One request word per cycle is
//   sustained while the receiver keeps taking results.
//   The result sits in an output register; req stays ready while that
//   register is empty or is being drained, so a stalled receiver holds the
//   pending result and blocks only the next request.
//   Favoured-class entries leave before normal ones; within a class the
//   earliest time leaves first and equal times leave in arrival order.
//   Reset (synchronous, active high) empties the queue and the output
//   register; the queue is ready in the first cycle after reset.
// ----------------------------------------------------------------------------
module two_class_sorted_priority_queue_core #(
  parameter int QUEUE_DEPTH = 16
) (
  input  wire          clk,
  input  wire          rst,
  tcspq_req_if.sink    req,
  tcspq_rsp_if.source  rsp
);
  import tcspq_pkg::*;

  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);
  localparam int CW = (CNT_BITS > OCC_W) ? CNT_BITS : OCC_W;

  logic [CW-1:0] cnt;
  logic [CW-1:0] cnt_next;
  logic          accept;
  logic          full;
  logic          empty;
  cell_ctl_t     ctl;
  entry_t        new_entry;
  entry_t        entries [QUEUE_DEPTH];
  logic          takes [QUEUE_DEPTH];

  logic          res_valid;
  logic          res_out_valid;
  entry_t        res_entry;
  logic [4:0]    res_occ;
  logic [1:0]    res_status;
  logic          ext_hit;
  logic [1:0]    status_next;

  assign req.ready = !res_valid || rsp.ready;
  assign accept    = req.valid && req.ready;
  assign full      = (cnt == CW'(QUEUE_DEPTH));
  assign empty     = (cnt == '0);

  assign new_entry.id       = req.entry_id;
  assign new_entry.prio     = req.is_priority;
  assign new_entry.arr_time = req.arrival_time;

  assign ctl.insert  = accept && (req.func == FUNC_INSERT) && !full;
  assign ctl.extract = accept && (req.func == FUNC_EXTRACT) && !empty;

  genvar gi;
  generate
    for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
      entry_t left_e;
      entry_t right_e;
      logic   left_t;
      if (gi == 0) begin : g_first
        assign left_e = new_entry;
        assign left_t = 1'b0;
      end else begin : g_mid
        assign left_e = entries[gi-1];
        assign left_t = takes[gi-1];
      end
      if (gi == QUEUE_DEPTH - 1) begin : g_last
        assign right_e = entries[gi];
      end else begin : g_inner
        assign right_e = entries[gi+1];
      end
      tcspq_cell u_cell (
        .clk         (clk),
        .ctl         (ctl),
        .new_entry   (new_entry),
        .left_entry  (left_e),
        .left_take   (left_t),
        .right_entry (right_e),
        .occupied    (CW'(gi) < cnt),
        .entry       (entries[gi]),
        .take        (takes[gi])
      );
    end
  endgenerate

  always_comb begin
    cnt_next    = cnt;
    status_next = ST_OK;
    ext_hit     = 1'b0;
    unique case (req.func)
      FUNC_INSERT: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          cnt_next = cnt + CW'(1);
        end
      end
      FUNC_EXTRACT: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else begin
          ext_hit  = 1'b1;
          cnt_next = cnt - CW'(1);
        end
      end
      FUNC_CLEAR: begin
        cnt_next = '0;
      end
      FUNC_NONE: begin
        cnt_next = cnt;
      end
      default: begin
        cnt_next = cnt;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      res_valid <= 1'b0;
    end else begin
      if (accept) begin
        cnt       <= cnt_next;
        res_valid <= 1'b1;
      end else if (rsp.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_out_valid <= ext_hit;
      res_entry     <= ext_hit ? entries[0] : '0;
      res_occ       <= cnt_next[4:0];
      res_status    <= status_next;
    end
  end

  assign rsp.valid        = res_valid;
  assign rsp.out_valid    = res_out_valid;
  assign rsp.out_id       = res_entry.id;
  assign rsp.out_priority = res_entry.prio;
  assign rsp.out_time     = res_entry.arr_time;
  assign rsp.occupancy    = res_occ;
  assign rsp.status       = res_status;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(QUEUE_DEPTH))
    else $error("queue count above depth");

  a_head_sorted: assert property (@(posedge clk) disable iff (rst)
    (cnt >= CW'(2)) |-> !goes_before(entries[1], entries[0]))
    else $error("head entry out of order");

  a_ext_result: assert property (@(posedge clk) disable iff (rst)
    ctl.extract |=> (rsp.valid && rsp.out_valid && rsp.status == ST_OK))
    else $error("extract did not yield an entry");

  a_ins_count: assert property (@(posedge clk) disable iff (rst)
    ctl.insert |=> (cnt == $past(cnt) + CW'(1)))
    else $error("insert did not grow the queue");

  a_valid_ok: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.out_valid) |-> (rsp.status == ST_OK))
    else $error("extracted entry with error status");
`endif

endmodule
`default_nettype wire

FILE: hdl/tcspq_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcspq_cell
// One slot of the sorted row. It compares the broadcast entry with its own
// and either keeps its entry, takes the new one, or takes a neighbour's.
// ----------------------------------------------------------------------------
module tcspq_cell (
  input  wire                     clk,
  input  wire tcspq_pkg::cell_ctl_t ctl,
  input  wire tcspq_pkg::entry_t  new_entry,
  input  wire tcspq_pkg::entry_t  left_entry,
  input  wire                     left_take,
  input  wire tcspq_pkg::entry_t  right_entry,
  input  wire                     occupied,
  output tcspq_pkg::entry_t       entry,
  output logic                    take
);
  import tcspq_pkg::*;

  entry_t entry_next;

  // An empty slot always counts as a place the new word may go.
  assign take = occupied ? goes_before(new_entry, entry) : 1'b1;

  always_comb begin
    entry_next = entry;
    priority if (ctl.insert) begin
      if (take) begin
        entry_next = left_take ? left_entry : new_entry;
      end
    end else if (ctl.extract) begin
      entry_next = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule
`default_nettype wire

FILE: test/two_class_sorted_priority_queue_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_class_sorted_priority_queue_core_tb
// Drives insert, extract, clear and unused operation words into the sorted
// queue and checks every result word against a queue model held in a small
// scoreboard. Both channels stall at random, with quiet stretches between.
// ----------------------------------------------------------------------------

class pq_scoreboard;

  typedef struct packed {
    logic        hit;
    logic [15:0] id;
    logic        prio;
    logic [15:0] arr_time;
    logic [4:0]  occupancy;
    logic [1:0]  status;
  } result_t;

  tcspq_pkg::entry_t held_q[$];
  result_t           awaited_q[$];
  int unsigned       depth;
  int unsigned       mismatches;

  function new(int unsigned depth_i);
    depth      = depth_i;
    mismatches = 0;
  endfunction

  function int unsigned pending();
    return awaited_q.size();
  endfunction

  // Applies one accepted request word to the model and queues its result.
  function void note_request(input logic [1:0] func, input logic prio,
                             input logic [15:0] arr_time, input logic [15:0] id);
    tcspq_pkg::entry_t fresh;
    result_t           res;
    int unsigned       pos;
    res            = '0;
    fresh.id       = id;
    fresh.prio     = prio;
    fresh.arr_time = arr_time;
    case (func)
      tcspq_pkg::FUNC_INSERT: begin
        if (held_q.size() >= depth) begin
          res.status = tcspq_pkg::ST_FULL;
        end else begin
          // Walk past every entry that stays ahead; equal times keep arrival order.
          pos = 0;
          while (pos < held_q.size() &&
                 !(prio > held_q[pos].prio ||
                   (prio == held_q[pos].prio && arr_time < held_q[pos].arr_time)))
            pos++;
          held_q.insert(pos, fresh);
        end
      end
      tcspq_pkg::FUNC_EXTRACT: begin
        if (held_q.size() == 0) begin
          res.status = tcspq_pkg::ST_EMPTY;
        end else begin
          res.hit      = 1'b1;
          res.id       = held_q[0].id;
          res.prio     = held_q[0].prio;
          res.arr_time = held_q[0].arr_time;
          void'(held_q.pop_front());
        end
      end
      tcspq_pkg::FUNC_CLEAR: begin
        held_q.delete();
      end
      default: begin
      end
    endcase
    res.occupancy = 5'(held_q.size());
    res.status    = (res.status === 2'bxx) ? tcspq_pkg::ST_OK : res.status;
    awaited_q.push_back(res);
  endfunction

  task report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task check_result(input logic hit, input logic [15:0] id, input logic prio,
                    input logic [15:0] arr_time, input logic [4:0] occupancy,
                    input logic [1:0] status);
    result_t want;
    if (awaited_q.size() == 0) begin
      report_mismatch("result word arrived with none outstanding");
      return;
    end
    want = awaited_q.pop_front();
    if (hit !== want.hit)
      report_mismatch($sformatf("out_valid %b, wanted %b", hit, want.hit));
    if (id !== want.id)
      report_mismatch($sformatf("out_id %h, wanted %h", id, want.id));
    if (prio !== want.prio)
      report_mismatch($sformatf("out_priority %b, wanted %b", prio, want.prio));
    if (arr_time !== want.arr_time)
      report_mismatch($sformatf("out_time %h, wanted %h", arr_time, want.arr_time));
    if (occupancy !== want.occupancy)
      report_mismatch($sformatf("occupancy %0d, wanted %0d", occupancy, want.occupancy));
    if (status !== want.status)
      report_mismatch($sformatf("status %0d, wanted %0d", status, want.status));
  endtask

endclass

module two_class_sorted_priority_queue_core_tb;
  import tcspq_pkg::*;

  localparam int QUEUE_DEPTH  = 16;
  localparam int RANDOM_ITEMS = 2000;

  logic clk = 1'b0;
  logic rst;
  bit   send_idle = 1'b0;

  tcspq_req_if req ();
  tcspq_rsp_if rsp ();

  pq_scoreboard sb = new(QUEUE_DEPTH);

  two_class_sorted_priority_queue_core #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  always #5 clk = ~clk;

  // The valid line is left high after a word is taken, so back-to-back words
  // never lower and raise it within one step.
  task automatic send_word(input logic [1:0] func, input logic prio,
                           input logic [15:0] arr_time, input logic [15:0] id);
    int unsigned gap;
    gap = send_idle ? $urandom_range(0, 16) : 0;
    if (gap != 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid        <= 1'b1;
    req.func         <= func;
    req.is_priority  <= prio;
    req.arrival_time <= arr_time;
    req.entry_id     <= id;
    do @(posedge clk); while (req.ready !== 1'b1);
    sb.note_request(func, prio, arr_time, id);
  endtask

  task automatic drain_results();
    req.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic run_directed();
    send_word(FUNC_EXTRACT, 1'b0, 16'h0000, 16'h0000);
    send_word(FUNC_NONE, 1'b1, 16'hFFFF, 16'hFFFF);
    send_word(FUNC_INSERT, 1'b0, 16'hFFFF, 16'hFFFF);
    send_word(FUNC_INSERT, 1'b1, 16'h0000, 16'h0000);
    send_word(FUNC_INSERT, 1'b0, 16'h0000, 16'h0001);
    send_word(FUNC_INSERT, 1'b1, 16'hFFFF, 16'h0002);
    // Equal keys in both classes must leave in the order they came.
    send_word(FUNC_INSERT, 1'b1, 16'h0000, 16'h0003);
    send_word(FUNC_INSERT, 1'b0, 16'hFFFF, 16'h0004);
    repeat (2) send_word(FUNC_EXTRACT, 1'b1, 16'hFFFF, 16'hFFFF);
    // Top the queue up to full, then offer one word too many.
    repeat (QUEUE_DEPTH - 3)
      send_word(FUNC_INSERT, 1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)),
                16'($urandom_range(0, 65535)));
    send_word(FUNC_CLEAR, 1'b0, 16'h0000, 16'h0000);
    send_word(FUNC_EXTRACT, 1'b0, 16'h0000, 16'h0000);
  endtask

  task automatic run_random();
    int unsigned sent;
    int unsigned seg_left;
    int unsigned ins_w;
    int unsigned ext_w;
    int unsigned pick;
    bit          narrow;
    logic [1:0]  func;
    logic [15:0] arr_time;
    sent     = 0;
    seg_left = 0;
    ins_w    = 50;
    ext_w    = 47;
    narrow   = 1'b0;
    while (sent < RANDOM_ITEMS) begin
      if (seg_left == 0) begin
        seg_left  = $urandom_range(40, 160);
        send_idle = ($urandom_range(0, 2) != 0);
        narrow    = $urandom_range(0, 1);
        case ($urandom_range(0, 2))
          0: begin
            ins_w = 75;
            ext_w = 22;
          end
          1: begin
            ins_w = 30;
            ext_w = 67;
          end
          default: begin
            ins_w = 50;
            ext_w = 47;
          end
        endcase
        if ($urandom_range(0, 3) == 0) drain_results();
      end
      pick = $urandom_range(0, 99);
      if (pick < ins_w) func = FUNC_INSERT;
      else if (pick < ins_w + ext_w) func = FUNC_EXTRACT;
      else if (pick < 99) func = FUNC_CLEAR;
      else func = FUNC_NONE;
      // A narrow key range makes ties within a class common.
      arr_time = narrow ? 16'($urandom_range(0, 3)) : 16'($urandom_range(0, 65535));
      send_word(func, 1'($urandom_range(0, 1)), arr_time, 16'($urandom_range(0, 65535)));
      if (func != FUNC_NONE) sent++;
      seg_left--;
    end
  endtask

  initial begin
    rst              <= 1'b1;
    req.valid        <= 1'b0;
    req.func         <= FUNC_NONE;
    req.is_priority  <= 1'b0;
    req.arrival_time <= 16'h0000;
    req.entry_id     <= 16'h0000;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    run_directed();
    drain_results();
    run_random();
    drain_results();
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("two_class_sorted_priority_queue_core regression: pass");
    end else begin
      $display("two_class_sorted_priority_queue_core regression: fail");
    end
    $finish;
  end

  initial begin : result_sink
    int unsigned gap;
    int unsigned run_left;
    bit          recv_idle;
    rsp.ready <= 1'b0;
    run_left  = 0;
    recv_idle = 1'b0;
    do @(posedge clk); while (rst !== 1'b0);
    forever begin
      if (run_left == 0) begin
        run_left  = $urandom_range(20, 120);
        recv_idle = ($urandom_range(0, 2) != 0);
      end
      run_left--;
      gap = recv_idle ? $urandom_range(0, 16) : 0;
      if (gap != 0) begin
        rsp.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      rsp.ready <= 1'b1;
      do @(posedge clk); while (rsp.valid !== 1'b1);
      sb.check_result(rsp.out_valid, rsp.out_id, rsp.out_priority, rsp.out_time,
                      rsp.occupancy, rsp.status);
    end
  end

  initial begin
    #5_000_000;
    $display("two_class_sorted_priority_queue_core regression: fail");
    $finish;
  end

endmodule
